// ===== rtl/core/crc16fr_pkg.sv =====
// Package for the CRC-16 frame receiver: fixed widths, register indexes,
// reset values, position codes and the byte-wide CRC-16/MODBUS update.
// No dependencies.
`timescale 1ns / 1ps

package crc16fr_pkg;

   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 16;
   localparam int PIDX_W      = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int HEADER_BYTES = 3;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_ONE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TWO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND   = 2'd2;

   localparam logic [BYTE_W-1:0] START_ONE_RESET = 8'hAB;
   localparam logic [BYTE_W-1:0] START_TWO_RESET = 8'hBA;
   localparam logic [BYTE_W-1:0] COMMAND_RESET   = 8'h55;

   // Fixed header positions; payload and CRC positions follow from the
   // payload length and live in the top level.
   localparam int POS_HUNT   = 0;
   localparam int POS_START2 = 1;
   localparam int POS_CMD    = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      logic              payload_valid;
      logic [PIDX_W-1:0] payload_index;
      logic              frame_end;
      logic              frame_ok;
      logic              header_error;
   } rsp_type;

   // One byte of reflected CRC-16/MODBUS, eight bit steps.
   function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/crc16fr_if.sv =====
// Valid/ready channel interfaces for the CRC-16 frame receiver.
// Depends on crc16fr_pkg for field widths.
`timescale 1ns / 1ps

interface crc16fr_req_if;
   logic                            valid;
   logic                            ready;
   logic [crc16fr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc16fr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [crc16fr_pkg::BYTE_W-1:0]  data_out;
   logic                            payload_valid;
   logic [crc16fr_pkg::PIDX_W-1:0]  payload_index;
   logic                            frame_end;
   logic                            frame_ok;
   logic                            header_error;

   modport source (output valid, output data_out, output payload_valid,
                   output payload_index, output frame_end, output frame_ok,
                   output header_error, input ready);
   modport sink   (input valid, input data_out, input payload_valid,
                   input payload_index, input frame_end, input frame_ok,
                   input header_error, output ready);
endinterface

// ===== rtl/core/crc16_frame_receiver.sv =====
// Top level of the CRC-16/MODBUS fixed-length frame receiver.
// Depends on crc16fr_pkg and the channel interfaces in crc16fr_if.sv.
`timescale 1ns / 1ps

// The block takes one received byte per item on the req_ch channel and returns
// exactly one result item per byte on the rsp_ch channel. The result echoes
// the byte and flags payload bytes with their index, the final CRC byte of a
// frame together with the CRC verdict, and header bytes that failed to match.
// The start bytes and the command code are written through the csr_ port by the
// user only while the block is idle; the block itself does not enforce this.
//
// A byte accepted at a clock edge is offered on rsp_ch from the next cycle
// on. Throughput is one item per cycle while rsp_ch does not stall; the frame
// state, the running CRC (byte-wide unrolled updates) and the result register
// are all updated in the cycle of acceptance, so bytes may arrive back to back.
// The result register decouples the two sides: req_ch.ready stays high while
// the result register is empty or is being emptied in the same cycle, so a
// stalled receiver holds its result and blocks only the next byte.
//
// Synchronous reset empties the result register, returns the block to
// hunting for the first start byte with the CRC at 0xFFFF, and loads the
// default start bytes 0xAB, 0xBA and command code 0x55.
module crc16_frame_receiver #(
   parameter int PAYLOAD_BYTES = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   crc16fr_req_if.sink                        req_ch,
   crc16fr_rsp_if.source                      rsp_ch,
   input  logic                               csr_we,
   input  logic [crc16fr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crc16fr_pkg::BYTE_W-1:0]     csr_wdata
);
   import crc16fr_pkg::*;

   // Positions run from hunting through header, payload, CRC low, CRC high.
   localparam int POS_W = $clog2(HEADER_BYTES + PAYLOAD_BYTES + 2);

   localparam logic [POS_W-1:0] P_HUNT      = POS_W'(POS_HUNT);
   localparam logic [POS_W-1:0] P_START2    = POS_W'(POS_START2);
   localparam logic [POS_W-1:0] P_CMD       = POS_W'(POS_CMD);
   localparam logic [POS_W-1:0] P_PAY_FIRST = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] P_PAY_LAST  = POS_W'(HEADER_BYTES + PAYLOAD_BYTES - 1);
   localparam logic [POS_W-1:0] P_CRC_LO    = POS_W'(HEADER_BYTES + PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] P_CRC_HI    = POS_W'(HEADER_BYTES + PAYLOAD_BYTES + 1);

   // Configuration registers.
   logic [BYTE_W-1:0] start_one_ff;
   logic [BYTE_W-1:0] start_two_ff;
   logic [BYTE_W-1:0] command_ff;

   // Frame state.
   logic [POS_W-1:0]  pos_ff,     pos_in;
   logic [CRC_W-1:0]  crc_ff,     crc_in;
   logic [BYTE_W-1:0] crc_low_ff, crc_low_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,       rsp_in;

   logic              req_accept;
   logic [BYTE_W-1:0] rx;
   logic [CRC_W-1:0]  crc_next;
   logic [CRC_W-1:0]  crc_restart;
   logic [BYTE_W-1:0] header_want;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rx           = req_ch.rx_byte;

   // Two byte-wide CRC updates side by side: continue the running CRC, or
   // restart it over a byte taken as a new start.
   assign crc_next    = crc_update(crc_ff, rx);
   assign crc_restart = crc_update(CRC_INIT, rx);
   assign header_want = (pos_ff == P_START2) ? start_two_ff : command_ff;

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;

      rsp_in               = '0;
      rsp_in.data_out      = rx;

      if (pos_ff inside {P_START2, P_CMD}) begin
         if (rx == header_want) begin
            crc_in = crc_next;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            // Header mismatch: a byte equal to the first start byte opens a
            // new frame, anything else returns to hunting.
            rsp_in.header_error = 1'b1;
            if (rx == start_one_ff) begin
               crc_in = crc_restart;
               pos_in = P_START2;
            end else begin
               crc_in = CRC_INIT;
               pos_in = P_HUNT;
            end
         end
      end else if (pos_ff inside {[P_PAY_FIRST:P_PAY_LAST]}) begin
         rsp_in.payload_valid = 1'b1;
         rsp_in.payload_index = PIDX_W'(pos_ff - P_PAY_FIRST);
         crc_in = crc_next;
         pos_in = pos_ff + POS_W'(1);
      end else if (pos_ff == P_CRC_LO) begin
         crc_low_in = rx;
         pos_in     = pos_ff + POS_W'(1);
      end else if (pos_ff == P_CRC_HI) begin
         rsp_in.frame_end = 1'b1;
         rsp_in.frame_ok  = ({rx, crc_low_ff} == crc_ff);
         crc_in = CRC_INIT;
         pos_in = P_HUNT;
      end else begin
         // Hunting; unused position codes are treated the same way.
         if (rx == start_one_ff) begin
            crc_in = crc_restart;
            pos_in = P_START2;
         end else begin
            crc_in = CRC_INIT;
            pos_in = P_HUNT;
         end
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_one_ff <= START_ONE_RESET;
         start_two_ff <= START_TWO_RESET;
         command_ff   <= COMMAND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_ONE: start_one_ff <= csr_wdata;
            CSR_START_TWO: start_two_ff <= csr_wdata;
            CSR_COMMAND:   command_ff   <= csr_wdata;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= P_HUNT;
         crc_ff       <= CRC_INIT;
         crc_low_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            pos_ff     <= pos_in;
            crc_ff     <= crc_in;
            crc_low_ff <= crc_low_in;
         end
      end
   end

   // Result payload needs no reset; it is only looked at with valid.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.data_out      = rsp_ff.data_out;
   assign rsp_ch.payload_valid = rsp_ff.payload_valid;
   assign rsp_ch.payload_index = rsp_ff.payload_index;
   assign rsp_ch.frame_end     = rsp_ff.frame_end;
   assign rsp_ch.frame_ok      = rsp_ff.frame_ok;
   assign rsp_ch.header_error  = rsp_ff.header_error;

endmodule

// ===== rtl/core/crc16fr_checker.sv =====
// Port-level checker for the CRC-16 frame receiver and its bind statement.
// Depends on crc16fr_pkg and the top level crc16_frame_receiver.
`timescale 1ns / 1ps

module crc16fr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [crc16fr_pkg::BYTE_W-1:0]     req_rx_byte,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [crc16fr_pkg::BYTE_W-1:0]     rsp_data_out,
   input logic                               rsp_payload_valid,
   input logic [crc16fr_pkg::PIDX_W-1:0]     rsp_payload_index,
   input logic                               rsp_frame_end,
   input logic                               rsp_frame_ok,
   input logic                               rsp_header_error
);
   import crc16fr_pkg::*;

   // A stalled result holds its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
                                  && $stable(rsp_frame_end))
      else $error("stalled result item changed");

   // An empty result register never blocks the input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty result register");

   // Every accepted byte shows up as the next result, echoed.
   a_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_data_out == $past(req_rx_byte))
      else $error("accepted byte not echoed in next result");

   // A CRC verdict only comes with the end of a frame.
   a_ok_needs_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_frame_end)
      else $error("frame_ok without frame_end");

   // Result flags are exclusive, and the index is zero outside the payload.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_payload_valid, rsp_frame_end, rsp_header_error})
                    && (rsp_payload_valid || rsp_payload_index == '0))
      else $error("inconsistent result flags");

endmodule

bind crc16_frame_receiver crc16fr_checker u_crc16fr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_rx_byte       (req_ch.rx_byte),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_data_out      (rsp_ch.data_out),
   .rsp_payload_valid (rsp_ch.payload_valid),
   .rsp_payload_index (rsp_ch.payload_index),
   .rsp_frame_end     (rsp_ch.frame_end),
   .rsp_frame_ok      (rsp_ch.frame_ok),
   .rsp_header_error  (rsp_ch.header_error)
);

// ===== tb/sv/crc16_frame_receiver_tb.sv =====
// Self-checking testbench for crc16_frame_receiver: frame bytes in, one result item per byte out.
// Depends on crc16fr_pkg, the channel interfaces in crc16fr_if.sv and the receiver top level.
`timescale 1ns / 1ps

module crc16_frame_receiver_tb;
   import crc16fr_pkg::*;

   localparam int PAYLOAD_LEN = 10;
   localparam int unsigned CYCLE_LIMIT = 400_000;
   // Index 3 is not a register; writes to it must leave the settings alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef logic [BYTE_W-1:0] payload_type [PAYLOAD_LEN];

   // Follows the receiver byte by byte: it keeps its own copy of the settings,
   // the frame position and the running CRC, and queues the result item that
   // each accepted byte must produce.
   class frame_tracker;
      logic [BYTE_W-1:0] start_one;
      logic [BYTE_W-1:0] start_two;
      logic [BYTE_W-1:0] command;
      int unsigned       position;
      logic [CRC_W-1:0]  running_crc;
      logic [BYTE_W-1:0] crc_low;
      int unsigned       payload_len;
      rsp_type           results_due[$];
      int unsigned       failures;

      function new(int unsigned len);
         payload_len = len;
         start_one   = START_ONE_RESET;
         start_two   = START_TWO_RESET;
         command     = COMMAND_RESET;
         position    = POS_HUNT;
         running_crc = CRC_INIT;
         crc_low     = '0;
         failures    = 0;
      endfunction

      // Reflected CRC-16, one input bit per step, least significant bit first.
      static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] acc, logic [BYTE_W-1:0] b);
         logic [CRC_W-1:0] r;
         logic             feedback;
         r = acc;
         for (int i = 0; i < BYTE_W; i++) begin
            feedback = r[0] ^ b[i];
            r = r >> 1;
            if (feedback) begin
               r = r ^ CRC_POLY;
            end
         end
         return r;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
         case (idx)
            CSR_START_ONE: begin
               start_one = v;
            end
            CSR_START_TWO: begin
               start_two = v;
            end
            CSR_COMMAND: begin
               command = v;
            end
            default: begin
            end
         endcase
      endfunction

      // A byte equal to the first start byte opens a new frame; anything else
      // leaves the receiver hunting.
      function void restart_or_hunt(logic [BYTE_W-1:0] b);
         if (b == start_one) begin
            running_crc = crc_step(CRC_INIT, b);
            position    = POS_START2;
         end else begin
            running_crc = CRC_INIT;
            position    = POS_HUNT;
         end
      endfunction

      function void receive_byte(logic [BYTE_W-1:0] b);
         rsp_type          r;
         logic [BYTE_W-1:0] header_byte;
         int unsigned      crc_lo_pos;
         crc_lo_pos = HEADER_BYTES + payload_len;
         r = '0;
         r.data_out = b;
         if (position == POS_START2 || position == POS_CMD) begin
            header_byte = (position == POS_START2) ? start_two : command;
            if (b == header_byte) begin
               running_crc = crc_step(running_crc, b);
               position++;
            end else begin
               r.header_error = 1'b1;
               restart_or_hunt(b);
            end
         end else if (position >= HEADER_BYTES && position < crc_lo_pos) begin
            r.payload_valid = 1'b1;
            r.payload_index = PIDX_W'(position - HEADER_BYTES);
            running_crc = crc_step(running_crc, b);
            position++;
         end else if (position == crc_lo_pos) begin
            crc_low = b;
            position++;
         end else if (position == crc_lo_pos + 1) begin
            r.frame_end = 1'b1;
            r.frame_ok  = ({b, crc_low} == running_crc);
            running_crc = CRC_INIT;
            position    = POS_HUNT;
         end else begin
            restart_or_hunt(b);
         end
         results_due.push_back(r);
      endfunction

      function void check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            failures++;
            $display("%0t: result item with none pending, expected nothing, actual data_out %0h",
                     $time, got.data_out);
            return;
         end
         want = results_due.pop_front();
         check_field("data_out", want.data_out, got.data_out);
         check_field("payload_valid", BYTE_W'(want.payload_valid),
                     BYTE_W'(got.payload_valid));
         check_field("payload_index", BYTE_W'(want.payload_index),
                     BYTE_W'(got.payload_index));
         check_field("frame_end", BYTE_W'(want.frame_end), BYTE_W'(got.frame_end));
         check_field("frame_ok", BYTE_W'(want.frame_ok), BYTE_W'(got.frame_ok));
         check_field("header_error", BYTE_W'(want.header_error),
                     BYTE_W'(got.header_error));
      endfunction

      function int unsigned outstanding();
         return results_due.size();
      endfunction

      function void report_leftovers();
         if (results_due.size() != 0) begin
            failures++;
            $display("%0t: %0d result items never arrived, expected 0 pending, actual %0d",
                     $time, results_due.size(), results_due.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   crc16fr_req_if req_bus ();
   crc16fr_rsp_if rsp_bus ();

   crc16_frame_receiver #(
      .PAYLOAD_BYTES (PAYLOAD_LEN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_tracker frames = new(PAYLOAD_LEN);

   // Gaps on each side can be switched off to get stretches of back-to-back
   // traffic in between the idling ones.
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap(bit enabled);
      int unsigned roll;
      if (!enabled) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // The result side stalls in runs of random length. Values seen at a rising
   // edge are the ones from before it, so every item accepted there is checked
   // against the oldest pending prediction.
   always @(posedge clock) begin : result_watch
      rsp_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.data_out      = rsp_bus.data_out;
         got.payload_valid = rsp_bus.payload_valid;
         got.payload_index = rsp_bus.payload_index;
         got.frame_end     = rsp_bus.frame_end;
         got.frame_ok      = rsp_bus.frame_ok;
         got.header_error  = rsp_bus.header_error;
         frames.match_result(got);
      end
   end

   initial begin : result_drain
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap(receiver_stalls);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Offers one byte and returns at the edge where it is taken. The byte is
   // handed to the tracker right there, so the prediction is always queued
   // before its result can show up in the following cycle. The valid line is only
   // lowered when a gap actually follows, never lowered and raised in one step.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit counted);
      int unsigned gap;
      gap = pick_gap(sender_gaps);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      frames.receive_byte(b);
      if (counted) begin
         bytes_sent++;
      end
   endtask

   // Stops sending, waits until every predicted result item has arrived and
   // then idles on so that the result register can empty.
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (frames.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      frames.set_register(idx, v);
   endtask

   task automatic apply_settings(input logic [BYTE_W-1:0] one, input logic [BYTE_W-1:0] two,
                                 input logic [BYTE_W-1:0] cmd);
      write_register(CSR_START_ONE, one);
      write_register(CSR_START_TWO, two);
      write_register(CSR_COMMAND, cmd);
   endtask

   function automatic payload_type random_payload();
      payload_type p;
      int unsigned style;
      style = $urandom_range(0, 9);
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         if (style == 0) begin
            p[i] = '0;
         end else if (style == 1) begin
            p[i] = '1;
         end else begin
            p[i] = BYTE_W'($urandom_range(0, 255));
         end
      end
      return p;
   endfunction

   // Sends a whole frame under the current settings; a nonzero crc_flip
   // corrupts the trailing CRC so that the frame must be reported bad.
   task automatic send_frame(input payload_type payload, input logic [CRC_W-1:0] crc_flip);
      logic [BYTE_W-1:0] header [HEADER_BYTES];
      logic [CRC_W-1:0]  crc;
      int                i;
      header[0] = frames.start_one;
      header[1] = frames.start_two;
      header[2] = frames.command;
      crc = CRC_INIT;
      for (i = 0; i < HEADER_BYTES; i++) begin
         send_byte(header[i], 1'b1);
         crc = frame_tracker::crc_step(crc, header[i]);
      end
      for (i = 0; i < PAYLOAD_LEN; i++) begin
         send_byte(payload[i], 1'b1);
         crc = frame_tracker::crc_step(crc, payload[i]);
      end
      crc = crc ^ crc_flip;
      send_byte(crc[7:0], 1'b1);
      send_byte(crc[15:8], 1'b1);
   endtask

   // A header that goes wrong at the second start byte or at the command.
   // Half of the wrong bytes equal the first start byte, which must be taken
   // as the start of a new frame.
   task automatic send_broken_header();
      logic [BYTE_W-1:0] b;
      send_byte(frames.start_one, 1'b1);
      if ($urandom_range(0, 1) == 0) begin
         if ($urandom_range(0, 1) == 0) begin
            b = frames.start_one;
         end else begin
            do begin
               b = BYTE_W'($urandom_range(0, 255));
            end while (b == frames.start_two);
         end
      end else begin
         send_byte(frames.start_two, 1'b1);
         if ($urandom_range(0, 1) == 0) begin
            b = frames.start_one;
         end else begin
            do begin
               b = BYTE_W'($urandom_range(0, 255));
            end while (b == frames.command);
         end
      end
      send_byte(b, 1'b1);
   endtask

   // A frame cut short inside the payload; whatever follows gets absorbed
   // into it, so the receiver sees frames that are out of step.
   task automatic send_truncated_frame();
      payload_type p;
      int unsigned keep;
      p = random_payload();
      keep = $urandom_range(0, PAYLOAD_LEN - 1);
      send_byte(frames.start_one, 1'b1);
      send_byte(frames.start_two, 1'b1);
      send_byte(frames.command, 1'b1);
      for (int i = 0; i < keep; i++) begin
         send_byte(p[i], 1'b1);
      end
   endtask

   // Mostly well-formed frames with random content, the rest bad CRCs, broken
   // headers, cut-off frames and line noise.
   task automatic run_random_traffic(input int unsigned quota);
      int unsigned first_count;
      int unsigned pick;
      int unsigned n;
      first_count = bytes_sent;
      while (bytes_sent - first_count < quota) begin
         if ($urandom_range(0, 19) == 0) begin
            sender_gaps = ~sender_gaps;
         end
         if ($urandom_range(0, 19) == 0) begin
            receiver_stalls = ~receiver_stalls;
         end
         if ($urandom_range(0, 39) == 0) begin
            pause_until_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_frame(random_payload(), '0);
         end else if (pick < 70) begin
            send_frame(random_payload(), CRC_W'($urandom_range(1, 65535)));
         end else if (pick < 85) begin
            send_broken_header();
         end else if (pick < 93) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_truncated_frame();
         end
      end
   endtask

   initial begin : stimulus
      payload_type edge_payload;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_START_ONE;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings. Noise while hunting is
      // echoed without any flag.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // Second start byte replaced by the first one: error, then a new start.
      send_byte(START_ONE_RESET, 1'b1);
      send_byte(START_ONE_RESET, 1'b1);
      send_byte(START_TWO_RESET, 1'b1);
      // Command replaced by the first start byte: error and a restart again.
      send_byte(START_ONE_RESET, 1'b1);
      // Second start byte wrong and unrelated: error, back to hunting.
      send_byte(8'h12, 1'b1);
      // A clean frame whose payload walks through the byte extremes.
      edge_payload = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0};
      send_frame(edge_payload, '0);
      pause_until_drained();

      run_random_traffic(190);

      // All-zero settings, plus a write to the unused index that must not
      // disturb them.
      pause_until_drained();
      apply_settings(8'h00, 8'h00, 8'h00);
      write_register(CSR_UNUSED, BYTE_W'($urandom_range(0, 255)));
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      run_random_traffic(190);

      pause_until_drained();
      apply_settings(8'hFF, 8'hFF, 8'hFF);
      run_random_traffic(190);

      pause_until_drained();
      apply_settings(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)));
      run_random_traffic(190);

      pause_until_drained();
      frames.report_leftovers();
      if (frames.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/crc16fr_pkg.sv
rtl/core/crc16fr_if.sv
rtl/core/crc16_frame_receiver.sv
rtl/core/crc16fr_checker.sv
tb/sv/crc16_frame_receiver_tb.sv
